// File: src/sorted_list_insert_delete_unit_defines.svh
// ----------------------------------------------------------------------------
// sorted list unit assertion macros
// shared assertion forms for the sorted list insert/delete unit
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLIDU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list unit check failed");

// next-cycle implication, disabled during reset
`define SLIDU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list unit check failed");

`endif

// File: src/slidu_pkg.sv
// ----------------------------------------------------------------------------
// slidu_pkg
// shared constants and types for the sorted list insert/delete unit
// ----------------------------------------------------------------------------
`default_nettype none

package slidu_pkg;

	localparam int VAL_W = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_DUMP   = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_REMOVED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_LISTED    = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic ins;
		logic del;
		logic rot;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/slidu_cell.sv
// ----------------------------------------------------------------------------
// slidu_cell
// one list slot: compares its value with the key and shifts with neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module slidu_cell (
	input  wire logic                        clk,
	input  wire slidu_pkg::cell_ctrl_t       ctrl,
	input  wire logic [slidu_pkg::VAL_W-1:0] key,
	input  wire logic                        occ,
	input  wire logic [slidu_pkg::VAL_W-1:0] left_val,
	input  wire logic [slidu_pkg::VAL_W-1:0] right_val,
	input  wire logic                        ge_prev,
	input  wire logic                        hit_prev,
	output logic      [slidu_pkg::VAL_W-1:0] val,
	output logic                             ge,
	output logic                             hit
);

	logic [slidu_pkg::VAL_W-1:0] val_q;
	logic                        eq;

	assign val = val_q;
	assign ge  = occ && ($signed(val_q) >= $signed(key));
	assign eq  = occ && (val_q == key);
	assign hit = hit_prev || eq;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (ge_prev) begin
				val_q <= left_val;
			end else if (ge || !occ) begin
				val_q <= key;
			end
		end else if (ctrl.del) begin
			if (hit) begin
				val_q <= right_val;
			end
		end else if (ctrl.rot) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

// File: src/sorted_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// ascending list of signed values held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// a request is taken on a rising edge with start high and busy low; mode
// selects insert, delete or dump, value is the key. results come out on
// status, value_out, count_after and last, each valid for the single cycle
// in which strobe is high; the receiver cannot stall them.
// insert and delete pass through the apply state after the request edge, in
// which every cell compares against the key and shifts with its neighbor;
// the result strobes in the following cycle, while busy is already low.
// insert lands before the first value greater than or equal to the key;
// a full list drops it. delete removes the first equal value.
// dump rotates the cell row once around, streaming one stored value per
// cycle from the head cell; busy stays high for the whole rotation. an
// empty dump gives a single result. an unused mode is accepted and gives
// no result.
// reset clears the count, so the list starts empty; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_delete_unit_defines.svh"

module sorted_list_insert_delete_unit #(
	parameter int CAPACITY = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    mode,
	input  wire logic [slidu_pkg::VAL_W-1:0]   value,
	output logic                               strobe,
	output logic      [2:0]                    status,
	output logic      [slidu_pkg::VAL_W-1:0]   value_out,
	output logic      [$clog2(CAPACITY + 1)-1:0] count_after,
	output logic                               last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int K_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_DUMP
	} state_t;

	state_t                      state_q;
	logic [1:0]                  mode_q;
	logic [slidu_pkg::VAL_W-1:0] key_q;
	logic [CNT_W-1:0]            count_q;
	logic [K_W-1:0]              k_q;
	logic                        strobe_q;
	logic [2:0]                  status_q;
	logic [slidu_pkg::VAL_W-1:0] value_out_q;
	logic [CNT_W-1:0]            count_after_q;
	logic                        last_q;

	slidu_pkg::cell_ctrl_t       ctrl;
	logic [slidu_pkg::VAL_W-1:0] cval [CAPACITY];
	logic [CAPACITY-1:0]         occ;
	logic [CAPACITY-1:0]         ge;
	logic [CAPACITY-1:0]         hit;
	logic                        full;
	logic                        found;
	logic [CNT_W-1:0]            k_ext;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = hit[CAPACITY-1];
	assign k_ext = CNT_W'(k_q);

	assign ctrl.ins = (state_q == S_APPLY) && (mode_q == slidu_pkg::MODE_INSERT) && !full;
	assign ctrl.del = (state_q == S_APPLY) && (mode_q == slidu_pkg::MODE_DELETE);
	assign ctrl.rot = (state_q == S_DUMP);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		slidu_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key       (key_q),
			.occ       (occ[i]),
			.left_val  ((i == 0) ? key_q : cval[(i + CAPACITY - 1) % CAPACITY]),
			.right_val (cval[(i + 1) % CAPACITY]),
			.ge_prev   ((i == 0) ? 1'b0 : ge[(i + CAPACITY - 1) % CAPACITY]),
			.hit_prev  ((i == 0) ? 1'b0 : hit[(i + CAPACITY - 1) % CAPACITY]),
			.val       (cval[i]),
			.ge        (ge[i]),
			.hit       (hit[i])
		);
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign count_after = count_after_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= slidu_pkg::MODE_INSERT;
			key_q         <= '0;
			count_q       <= '0;
			k_q           <= '0;
			strobe_q      <= 1'b0;
			status_q      <= slidu_pkg::ST_INSERTED;
			value_out_q   <= '0;
			count_after_q <= '0;
			last_q        <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						key_q   <= value;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q     <= S_IDLE;
					value_out_q <= key_q;
					last_q      <= 1'b1;
					unique case (mode_q)
						slidu_pkg::MODE_INSERT: begin
							strobe_q <= 1'b1;
							if (full) begin
								status_q      <= slidu_pkg::ST_FULL;
								count_after_q <= count_q;
							end else begin
								status_q      <= slidu_pkg::ST_INSERTED;
								count_after_q <= count_q + 1'b1;
								count_q       <= count_q + 1'b1;
							end
						end
						slidu_pkg::MODE_DELETE: begin
							strobe_q <= 1'b1;
							if (found) begin
								status_q      <= slidu_pkg::ST_REMOVED;
								count_after_q <= count_q - 1'b1;
								count_q       <= count_q - 1'b1;
							end else begin
								status_q      <= slidu_pkg::ST_NOT_FOUND;
								count_after_q <= count_q;
							end
						end
						slidu_pkg::MODE_DUMP: begin
							if (count_q == '0) begin
								strobe_q      <= 1'b1;
								status_q      <= slidu_pkg::ST_EMPTY;
								count_after_q <= '0;
							end else begin
								state_q <= S_DUMP;
								k_q     <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				S_DUMP: begin
					strobe_q      <= (k_ext < count_q);
					status_q      <= slidu_pkg::ST_LISTED;
					value_out_q   <= cval[0];
					count_after_q <= count_q;
					last_q        <= (k_ext == (count_q - 1'b1));
					k_q           <= k_q + 1'b1;
					if (k_q == K_W'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SLIDU_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLIDU_ASSERT_NEXT(a_count_moves_on_apply, 1'b1,
		$stable(count_q) || ($past(state_q) == S_APPLY))
	`SLIDU_ASSERT_IMPL(a_full_count, strobe_q && (status_q == slidu_pkg::ST_FULL),
		count_after_q == CNT_W'(CAPACITY))
	`SLIDU_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule

`default_nettype wire
